FILE: hdl/aes256_block_encrypt_core_defines.svh
// Assertion macros for the AES-256 encrypt core.
// Taken in by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef AES256_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define AES256_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`ifndef SYNTH
`define A256_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define A256_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define A256_ASSERT_IMPL(label, prop, msg)
`define A256_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hdl/a256_pkg.sv
// Shared constants for the AES-256 encrypt core: commands, store geometry, S-box.
// No dependencies.
package a256_pkg;

    localparam int NumRoundKeys = 15;
    localparam int StoreDepth   = 2 * NumRoundKeys;
    localparam int StoreWidth   = 64;
    localparam int StoreAddrW   = $clog2(StoreDepth);

    localparam logic [1:0] CMD_LOAD_HI = 2'd0;
    localparam logic [1:0] CMD_LOAD_LO = 2'd1;
    localparam logic [1:0] CMD_ENCRYPT = 2'd2;

    localparam logic [3:0] LAST_ROUND = 4'(NumRoundKeys - 1);

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

endpackage

FILE: hdl/a256_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module a256_ram #(
    parameter int Width = 64,
    parameter int Depth = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/a256_mixcol.sv
// One-column MixColumns and AddRoundKey step, used once per column transfer.
// No dependencies.
module a256_mixcol (
    input  logic [31:0] i_col,     // byte in row 0 in bits 31:24
    input  logic [31:0] i_key,
    input  logic        i_bypass,  // final round: no MixColumns
    output logic [31:0] o_col
);
    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    logic [7:0] a0, a1, a2, a3, all;
    logic [31:0] mixed;

    always_comb begin
        a0  = i_col[31:24];
        a1  = i_col[23:16];
        a2  = i_col[15:8];
        a3  = i_col[7:0];
        all = a0 ^ a1 ^ a2 ^ a3;
        mixed = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                 a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
        o_col = (i_bypass ? i_col : mixed) ^ i_key;
    end
endmodule

FILE: hdl/aes256_block_encrypt_core.sv
// AES-256 encrypt core: usage notes follow.
// Slave channel: tuser carries the command, tdata key slot and block/key halves.
// Load transfers (command 0/1) to slots 0-14 write one 64-bit half of a round key into the key RAM;
// they give no result and the core is ready again the next cycle.
// An encrypt transfer runs the cipher byte-serially: each round fetches its key
// (one RAM read port), substitutes and shifts one byte a cycle and mixes one column
// a cycle; the last round skips MixColumns. The initial key add plus 14 rounds finish
// the block, and the result is then loaded into the output register from the done state.
// The slave side is ready only while no block is being processed, so a new encrypt
// transfer is taken only after the previous block has left for the output register.
// The master tdata holds cipher_high in the low 64 bits, cipher_low above it.
// The output register holds a result until it is taken; a new block may be accepted
// meanwhile, and it waits at its end until the previous result has gone.
// Reset (synchronous, active low) clears control only; round keys must be reloaded
// after power-up before encrypting, the key RAM is not cleared.
// Depends on a256_pkg, a256_ram, a256_mixcol and the defines header.
`include "aes256_block_encrypt_core_defines.svh"
module aes256_block_encrypt_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [135:0] i_s_axis_tdata,  // key_slot[3:0], data_high[67:4], data_low[131:68]
    input  logic [1:0]   i_s_axis_tuser,  // cmd[1:0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata   // cipher_high[63:0], cipher_low[127:64]
);
    localparam int AddrW = a256_pkg::StoreAddrW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEY  = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_MIX  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]   r_fsm, n_fsm;
    logic [3:0]   r_round, n_round;
    logic [3:0]   r_cnt, n_cnt;
    logic [127:0] r_state, n_state;
    logic [127:0] r_tmp, n_tmp;
    logic [127:0] r_key, n_key;
    logic         r_ovalid, n_ovalid;
    logic [127:0] r_odata, n_odata;

    logic         w_acc;
    logic [1:0]   w_cmd;
    logic [3:0]   w_slot;
    logic         w_we;
    logic [AddrW-1:0] w_raddr;
    logic [63:0]  w_rdata;
    logic [3:0]   w_src;
    logic [127:0] w_sh;
    logic [31:0]  w_col;

    assign w_cmd  = i_s_axis_tuser;
    assign w_slot = i_s_axis_tdata[3:0];
    assign o_s_axis_tready = (r_fsm == S_IDLE);
    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_we   = w_acc && (w_cmd == a256_pkg::CMD_LOAD_HI || w_cmd == a256_pkg::CMD_LOAD_LO)
                    && (w_slot != 4'd15);
    assign w_raddr = AddrW'({r_round, r_cnt[0]});

    // round key store
    a256_ram #(
        .Width(a256_pkg::StoreWidth),
        .Depth(a256_pkg::StoreDepth)
    ) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(AddrW'({w_slot, w_cmd[0]})),
        .i_wdata(i_s_axis_tdata[67:4]),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // ShiftRows source byte for output byte r_cnt (row r, column c)
    assign w_src = {r_cnt[3:2] + r_cnt[1:0], r_cnt[1:0]};
    assign w_sh  = r_state << {w_src, 3'b000};

    // column unit
    a256_mixcol u_mix (
        .i_col   (r_tmp[127:96]),
        .i_key   (r_key[127:96]),
        .i_bypass(r_round == a256_pkg::LAST_ROUND),
        .o_col   (w_col)
    );

    // sequencer
    always_comb begin
        n_fsm    = r_fsm;
        n_round  = r_round;
        n_cnt    = r_cnt;
        n_state  = r_state;
        n_tmp    = r_tmp;
        n_key    = r_key;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_fsm)
            S_IDLE: begin
                if (w_acc && w_cmd == a256_pkg::CMD_ENCRYPT) begin
                    n_state = {i_s_axis_tdata[67:4], i_s_axis_tdata[131:68]};
                    n_round = 4'd0;
                    n_cnt   = 4'd0;
                    n_fsm   = S_KEY;
                end
            end
            S_KEY: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd1) begin
                    n_key[127:64] = w_rdata;
                end
                if (r_cnt == 4'd2) begin
                    n_key[63:0] = w_rdata;
                    n_cnt = 4'd0;
                    if (r_round == 4'd0) begin
                        n_state = r_state ^ {r_key[127:64], w_rdata};
                        n_round = 4'd1;
                    end else begin
                        n_fsm = S_SUB;
                    end
                end
            end
            S_SUB: begin
                n_tmp = {r_tmp[119:0], a256_pkg::SBOX[w_sh[127:120]]};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_cnt = 4'd0;
                    n_fsm = S_MIX;
                end
            end
            S_MIX: begin
                n_state = {r_state[95:0], w_col};
                n_tmp   = {r_tmp[95:0], 32'd0};
                n_key   = {r_key[95:0], 32'd0};
                n_cnt   = r_cnt + 4'd1;
                if (r_cnt == 4'd3) begin
                    n_cnt = 4'd0;
                    if (r_round == a256_pkg::LAST_ROUND) begin
                        n_fsm = S_DONE;
                    end else begin
                        n_round = r_round + 4'd1;
                        n_fsm   = S_KEY;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {r_state[63:0], r_state[127:64]};
                    n_fsm    = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_round  <= 4'd0;
            r_cnt    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_round  <= n_round;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_tmp   <= n_tmp;
        r_key   <= n_key;
        r_odata <= n_odata;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    `A256_ASSERT_NEXT(a_enc_starts, w_acc && w_cmd == a256_pkg::CMD_ENCRYPT, r_fsm == S_KEY,
        "encrypt transfer did not start key fetch")
    `A256_ASSERT_NEXT(a_load_idle, w_acc && w_cmd != a256_pkg::CMD_ENCRYPT, r_fsm == S_IDLE,
        "load transfer left the idle state")
    `A256_ASSERT_IMPL(a_done_last, (r_fsm != S_DONE) || (r_round == a256_pkg::LAST_ROUND),
        "block finished before the last round")
    `A256_ASSERT_NEXT(a_mix_next, r_fsm == S_MIX,
        r_fsm == S_MIX || r_fsm == S_KEY || r_fsm == S_DONE, "bad step after column mix")
endmodule

FILE: dv/aes256_block_encrypt_core_tb.sv
// Self-checking testbench for the AES-256 block encrypt core: loads round keys,
// encrypts blocks and compares each ciphertext with a cipher computed here.
// Depends on a256_pkg and the core RTL.
module aes256_block_encrypt_core_tb;

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 400;
    localparam int HoldCycles    = 1000;
    localparam int RandomItems   = 850;
    localparam int QuietItems    = 100;
    localparam logic [1:0] CmdUnused = 2'd3;

    // Round key store copy, expected ciphertexts and mismatch count
    class cipher_scoreboard;
        logic [63:0]  key_copy [a256_pkg::StoreDepth];
        logic [127:0] expected_cipher [$];
        int           errors;

        function new();
            errors = 0;
            foreach (key_copy[i]) key_copy[i] = '0;
        endfunction

        function logic [7:0] xtime(logic [7:0] x);
            return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        endfunction

        function logic [127:0] round_key(int k);
            return {key_copy[2 * k], key_copy[2 * k + 1]};
        endfunction

        // SubBytes and ShiftRows; byte i is row i%4, column i/4, byte 0 on top
        function logic [127:0] sub_shift(logic [127:0] st);
            logic [127:0] t;
            int src;
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    src = r + 4 * ((c + r) & 3);
                    t[127 - 8 * (r + 4 * c) -: 8] = a256_pkg::SBOX[st[127 - 8 * src -: 8]];
                end
            end
            return t;
        endfunction

        function logic [127:0] mix_columns(logic [127:0] st);
            logic [127:0] t;
            logic [7:0] a0, a1, a2, a3, all;
            for (int c = 0; c < 4; c++) begin
                a0 = st[127 - 32 * c -: 8];
                a1 = st[119 - 32 * c -: 8];
                a2 = st[111 - 32 * c -: 8];
                a3 = st[103 - 32 * c -: 8];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
                t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
                t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
                t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
            end
            return t;
        endfunction

        function logic [127:0] encrypt_block(logic [127:0] plain);
            logic [127:0] st;
            st = plain ^ round_key(0);
            for (int r = 1; r < a256_pkg::NumRoundKeys - 1; r++)
                st = mix_columns(sub_shift(st)) ^ round_key(r);
            return sub_shift(st) ^ round_key(a256_pkg::NumRoundKeys - 1);
        endfunction

        // Accepted input transfer: update keys or queue a ciphertext
        function void note_transfer(logic [1:0] cmd, logic [3:0] slot,
                                    logic [63:0] hi, logic [63:0] lo);
            if ((cmd == a256_pkg::CMD_LOAD_HI || cmd == a256_pkg::CMD_LOAD_LO)
                    && slot < a256_pkg::NumRoundKeys)
                key_copy[2 * slot + (cmd == a256_pkg::CMD_LOAD_LO ? 1 : 0)] = hi;
            else if (cmd == a256_pkg::CMD_ENCRYPT)
                expected_cipher.push_back(encrypt_block({hi, lo}));
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        // Accepted output transfer; tdata holds cipher_high low, cipher_low high
        task check_cipher(logic [127:0] tdata);
            logic [127:0] want;
            if (expected_cipher.size() == 0) begin
                report_mismatch("unexpected result", tdata[63:0], '0);
            end else begin
                want = expected_cipher.pop_front();
                if (tdata[63:0] !== want[127:64])
                    report_mismatch("cipher_high", tdata[63:0], want[127:64]);
                if (tdata[127:64] !== want[63:0])
                    report_mismatch("cipher_low", tdata[127:64], want[63:0]);
            end
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [135:0] i_s_axis_tdata = '0;  // key_slot[3:0], data_high[67:4], data_low[131:68]
    logic [1:0]   i_s_axis_tuser = '0;  // cmd[1:0]
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [127:0] o_m_axis_tdata;       // cipher_high[63:0], cipher_low[127:64]

    cipher_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int idle_cycles = 0;

    aes256_block_encrypt_core DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int stall_left = 0;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_cipher(o_m_axis_tdata);
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one item and wait for its transfer
    task send_item(logic [1:0] cmd, logic [3:0] slot, logic [63:0] hi, logic [63:0] lo);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {4'h0, lo, hi, slot};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_transfer(cmd, slot, hi, lo);
    endtask

    task sender_gap();
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 7);
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [1:0] cmd;
        int pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill every key entry before the first encrypt
        for (int k = 0; k < a256_pkg::NumRoundKeys; k++) begin
            send_item(a256_pkg::CMD_LOAD_HI, 4'(k), rand64(), rand64());
            send_item(a256_pkg::CMD_LOAD_LO, 4'(k), rand64(), rand64());
        end
        send_item(a256_pkg::CMD_ENCRYPT, 4'h0, '0, '0);
        send_item(a256_pkg::CMD_ENCRYPT, 4'hf, '1, '1);
        send_item(a256_pkg::CMD_ENCRYPT, 4'h5, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        // Out-of-range slot and unused command are ignored, then slots 14 and 0 get new keys
        send_item(a256_pkg::CMD_LOAD_HI, 4'hf, '0, '1);
        send_item(a256_pkg::CMD_LOAD_LO, 4'hf, '1, '0);
        send_item(CmdUnused, 4'h3, '1, '1);
        send_item(a256_pkg::CMD_LOAD_HI, 4'he, '1, '0);
        send_item(a256_pkg::CMD_LOAD_LO, 4'he, '0, '1);
        send_item(a256_pkg::CMD_LOAD_HI, 4'h0, '0, '0);
        send_item(a256_pkg::CMD_LOAD_LO, 4'h0, '1, '1);
        send_item(a256_pkg::CMD_ENCRYPT, 4'h0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        send_item(a256_pkg::CMD_ENCRYPT, 4'h0, rand64(), rand64());

        // Random: loads over all slots, encrypts, ignored items; one receiver hold-off and a quiet tail
        for (int i = 0; i < RandomItems; i++) begin
            if (i == 300) begin
                hold_request = 1'b1;
                for (int j = 0; j < 4; j++)
                    send_item(a256_pkg::CMD_ENCRYPT, 4'($urandom), rand64(), rand64());
            end
            if (i == RandomItems - QuietItems) quiet = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick < 5)       cmd = a256_pkg::CMD_LOAD_HI;
            else if (pick < 10) cmd = a256_pkg::CMD_LOAD_LO;
            else if (pick < 18) cmd = a256_pkg::CMD_ENCRYPT;
            else                cmd = CmdUnused;
            send_item(cmd, 4'($urandom_range(0, 15)), rand64(), rand64());
            sender_gap();
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain
        while (sb.expected_cipher.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_cipher.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
